// ===== rtl/core/swd_pkg.sv =====
package swd_pkg;

   localparam int unsigned HeaderWidth = 8;
   localparam int unsigned WordWidth   = 32;
   localparam int unsigned CountWidth  = 6;
   localparam int unsigned AckWidth    = 3;

   // Packed stream widths, whole bytes.
   localparam int unsigned ReqDataWidth = 48;
   localparam int unsigned RspDataWidth = 40;

   // Bit counts that end the longer phases.
   localparam logic [CountWidth-1:0] HeaderBits   = 6'd8;
   localparam logic [CountWidth-1:0] AckBits      = 6'd3;
   localparam logic [CountWidth-1:0] ReadBits     = 6'd32;
   localparam logic [CountWidth-1:0] WriteParity  = 6'd33;
   localparam logic [CountWidth-1:0] WriteLast    = 6'd40;
   localparam logic [CountWidth-1:0] SkipLast     = 6'd33;

   // Header bit that marks a read.
   localparam int unsigned HeaderReadBit = 2;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_HDR   = 3'd1,
      PH_TURN  = 3'd2,
      PH_ACK   = 3'd3,
      PH_READ  = 3'd4,
      PH_WRITE = 3'd5,
      PH_LAST  = 3'd6,
      PH_SKIP  = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      ACK_OK    = 3'd1,
      ACK_WAIT  = 3'd2,
      ACK_FAULT = 3'd4
   } ack_code_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_WAIT   = 3'd1,
      ST_FAULT  = 3'd2,
      ST_PARITY = 3'd3,
      ST_NO_ACK = 3'd4
   } status_type;

   typedef struct packed {
      logic                   line_in;
      logic [WordWidth-1:0]   write_data;
      logic [HeaderWidth-1:0] header;
      logic                   start_req;
   } req_item_type;

   typedef struct packed {
      logic [WordWidth-1:0] read_data;
      logic [AckWidth-1:0]  ack_bits;
      logic [2:0]           status;
      logic                 done_res;
      logic                 swdio_drive;
      logic                 swdio_out;
   } rsp_item_type;

endpackage

// ===== rtl/core/swd_in_reg.sv =====
// Input register: holds one item until the sequencer takes it.
module swd_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  swd_pkg::req_item_type in_item,
   input  logic                  take,
   output logic                  held_valid,
   output swd_pkg::req_item_type held_item
);

   logic                  valid_ff;
   logic                  valid_in;
   swd_pkg::req_item_type item_ff;

   assign in_ready   = !valid_ff || take;
   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

// ===== rtl/core/swd_seq.sv =====
// Transaction sequencer: one wire tick per step.
module swd_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  swd_pkg::req_item_type item,
   output swd_pkg::rsp_item_type result
);

   swd_pkg::phase_type                     phase_ff;
   swd_pkg::phase_type                     phase_in;
   logic [swd_pkg::CountWidth-1:0]         bit_count_ff;
   logic [swd_pkg::CountWidth-1:0]         bit_count_in;
   logic [swd_pkg::WordWidth-1:0]          shift_word_ff;
   logic [swd_pkg::WordWidth-1:0]          shift_word_in;
   logic [swd_pkg::HeaderWidth-1:0]        header_hold_ff;
   logic [swd_pkg::HeaderWidth-1:0]        header_hold_in;
   logic [swd_pkg::WordWidth-1:0]          write_hold_ff;
   logic [swd_pkg::WordWidth-1:0]          write_hold_in;
   logic [swd_pkg::AckWidth-1:0]           ack_hold_ff;
   logic [swd_pkg::AckWidth-1:0]           ack_hold_in;
   logic                                   parity_acc_ff;
   logic                                   parity_acc_in;
   logic [swd_pkg::CountWidth-1:0]         count_inc;
   logic [swd_pkg::CountWidth-1:0]         count_dec;
   logic [swd_pkg::AckWidth-1:0]           ack_next;

   assign count_inc = bit_count_ff + 6'd1;
   assign count_dec = bit_count_ff - 6'd1;

   // The acknowledge bit lands at the current count; counts stay below three here.
   always_comb begin
      ack_next = ack_hold_ff;
      case (bit_count_ff[1:0])
         2'd0:    ack_next[0] = ack_hold_ff[0] | item.line_in;
         2'd1:    ack_next[1] = ack_hold_ff[1] | item.line_in;
         2'd2:    ack_next[2] = ack_hold_ff[2] | item.line_in;
         default: ack_next = ack_hold_ff;
      endcase
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         swd_pkg::PH_IDLE: begin
            if (item.start_req) begin
               phase_in = swd_pkg::PH_HDR;
            end
         end
         swd_pkg::PH_HDR: begin
            if (count_inc >= swd_pkg::HeaderBits) begin
               phase_in = swd_pkg::PH_TURN;
            end
         end
         swd_pkg::PH_TURN: begin
            phase_in = swd_pkg::PH_ACK;
         end
         swd_pkg::PH_ACK: begin
            if (count_inc >= swd_pkg::AckBits) begin
               if (ack_next == swd_pkg::ACK_OK) begin
                  if (header_hold_ff[swd_pkg::HeaderReadBit]) begin
                     phase_in = swd_pkg::PH_READ;
                  end else begin
                     phase_in = swd_pkg::PH_WRITE;
                  end
               end else if (ack_next == swd_pkg::ACK_WAIT ||
                            ack_next == swd_pkg::ACK_FAULT) begin
                  phase_in = swd_pkg::PH_LAST;
               end else begin
                  phase_in = swd_pkg::PH_SKIP;
               end
            end
         end
         swd_pkg::PH_READ: begin
            if (bit_count_ff >= swd_pkg::ReadBits) begin
               phase_in = swd_pkg::PH_LAST;
            end
         end
         swd_pkg::PH_WRITE: begin
            if (bit_count_ff >= swd_pkg::WriteLast) begin
               phase_in = swd_pkg::PH_IDLE;
            end
         end
         swd_pkg::PH_LAST: begin
            phase_in = swd_pkg::PH_IDLE;
         end
         swd_pkg::PH_SKIP: begin
            if (bit_count_ff >= swd_pkg::SkipLast) begin
               phase_in = swd_pkg::PH_IDLE;
            end
         end
         default: phase_in = swd_pkg::PH_IDLE;
      endcase
   end

   // Datapath and result.
   always_comb begin
      bit_count_in   = bit_count_ff;
      shift_word_in  = shift_word_ff;
      header_hold_in = header_hold_ff;
      write_hold_in  = write_hold_ff;
      ack_hold_in    = ack_hold_ff;
      parity_acc_in  = parity_acc_ff;
      result         = '0;
      case (phase_ff)
         swd_pkg::PH_IDLE: begin
            result.swdio_drive = 1'b1;
            if (item.start_req) begin
               header_hold_in   = item.header;
               write_hold_in    = item.write_data;
               result.swdio_out = item.header[0];
               bit_count_in     = 6'd1;
            end
         end
         swd_pkg::PH_HDR: begin
            result.swdio_drive = 1'b1;
            result.swdio_out   = header_hold_ff[bit_count_ff[2:0]];
            if (count_inc >= swd_pkg::HeaderBits) begin
               bit_count_in = '0;
            end else begin
               bit_count_in = count_inc;
            end
         end
         swd_pkg::PH_TURN: begin
            ack_hold_in  = '0;
            bit_count_in = '0;
         end
         swd_pkg::PH_ACK: begin
            ack_hold_in = ack_next;
            if (count_inc >= swd_pkg::AckBits) begin
               bit_count_in = '0;
               if (ack_next == swd_pkg::ACK_OK &&
                   header_hold_ff[swd_pkg::HeaderReadBit]) begin
                  shift_word_in = '0;
                  parity_acc_in = 1'b0;
               end
            end else begin
               bit_count_in = count_inc;
            end
         end
         swd_pkg::PH_READ: begin
            parity_acc_in = parity_acc_ff ^ item.line_in;
            if (bit_count_ff < swd_pkg::ReadBits) begin
               shift_word_in = {item.line_in, shift_word_ff[swd_pkg::WordWidth-1:1]};
               bit_count_in  = count_inc;
            end else begin
               bit_count_in = '0;
            end
         end
         swd_pkg::PH_WRITE: begin
            if (bit_count_ff != '0) begin
               result.swdio_drive = 1'b1;
               if (bit_count_ff <= swd_pkg::ReadBits) begin
                  result.swdio_out = write_hold_ff[count_dec[4:0]];
               end else if (bit_count_ff == swd_pkg::WriteParity) begin
                  result.swdio_out = ^write_hold_ff;
               end
            end
            if (bit_count_ff >= swd_pkg::WriteLast) begin
               result.done_res = 1'b1;
               result.status   = swd_pkg::ST_OK;
               result.ack_bits = ack_hold_ff;
               bit_count_in    = '0;
            end else begin
               bit_count_in = count_inc;
            end
         end
         swd_pkg::PH_LAST: begin
            result.done_res = 1'b1;
            result.ack_bits = ack_hold_ff;
            if (ack_hold_ff == swd_pkg::ACK_OK) begin
               result.status    = parity_acc_ff ? swd_pkg::ST_PARITY : swd_pkg::ST_OK;
               result.read_data = shift_word_ff;
            end else if (ack_hold_ff == swd_pkg::ACK_WAIT) begin
               result.status = swd_pkg::ST_WAIT;
            end else begin
               result.status = swd_pkg::ST_FAULT;
            end
            bit_count_in = '0;
         end
         swd_pkg::PH_SKIP: begin
            if (bit_count_ff >= swd_pkg::SkipLast) begin
               result.done_res = 1'b1;
               result.status   = swd_pkg::ST_NO_ACK;
               result.ack_bits = ack_hold_ff;
               bit_count_in    = '0;
            end else begin
               bit_count_in = count_inc;
            end
         end
         default: bit_count_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= swd_pkg::PH_IDLE;
         bit_count_ff   <= '0;
         shift_word_ff  <= '0;
         header_hold_ff <= '0;
         write_hold_ff  <= '0;
         ack_hold_ff    <= '0;
         parity_acc_ff  <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         shift_word_ff  <= shift_word_in;
         header_hold_ff <= header_hold_in;
         write_hold_ff  <= write_hold_in;
         ack_hold_ff    <= ack_hold_in;
         parity_acc_ff  <= parity_acc_in;
      end
   end

   // Done only comes out of the three closing phases.
   assert property (@(posedge clock) disable iff (reset)
      (step && result.done_res) |->
         (phase_ff == swd_pkg::PH_WRITE || phase_ff == swd_pkg::PH_LAST ||
          phase_ff == swd_pkg::PH_SKIP))
      else $error("done outside a closing phase");

   // A finished transaction always returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      (step && result.done_res) |=> (phase_ff == swd_pkg::PH_IDLE))
      else $error("sequencer not idle after done");

   // The header is always driven by the host.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == swd_pkg::PH_HDR) |->
         (result.swdio_drive && bit_count_ff < swd_pkg::HeaderBits))
      else $error("header tick released or out of range");

   // A status code other than OK appears only on the closing tick.
   assert property (@(posedge clock) disable iff (reset)
      (result.status != swd_pkg::ST_OK) |-> result.done_res)
      else $error("status without done");

endmodule

// ===== rtl/core/swd_out_reg.sv =====
// Result register: holds one finished item until the consumer takes it.
module swd_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  swd_pkg::rsp_item_type load_item,
   output logic                  can_load,
   output logic                  out_valid,
   input  logic                  out_ready,
   output swd_pkg::rsp_item_type out_item
);

   logic                  valid_ff;
   logic                  valid_in;
   swd_pkg::rsp_item_type item_ff;

   assign can_load  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

endmodule

// ===== rtl/core/swd_host_transaction_unit.sv =====
// Serial Wire Debug host transaction sequencer. Each input item stands for one
// wire clock tick and produces exactly one result item: the level and drive
// enable for the data line on that tick, and on the closing tick of a
// transaction a done flag (rsp_tlast) with status, raw acknowledge and, for a
// read, the received word. A transaction starts on an item with start_req set
// while idle; that tick already drives header bit 0. The header goes out least
// significant bit first, then one turnaround and three acknowledge bits are
// sampled. An OK read samples 32 data bits and parity and ends after one more
// turnaround, reporting a parity error if the parity does not match; an OK
// write takes one turnaround and then drives 32 data bits, parity and seven
// low bits; WAIT or FAULT end after one turnaround, and any other acknowledge
// skips 34 released ticks and reports no valid acknowledge. The block takes one
// item per clock cycle while the result side keeps up: an item passes an input
// register and the sequencer step into a result register, which offers the
// result; the sequencer steps only while the result register has room. The
// sustained rate is one item per cycle while rsp_tready stays high and is set
// by the sequencer step, whose state feeds the next tick. req_tready follows
// rsp_tready combinationally when both registers are full.
module swd_host_transaction_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] start_req, [8:1] header, [40:9] write_data, [41] line_in, [47:42] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] swdio_out, [1] swdio_drive, [4:2] status, [7:5] ack_bits,
   // [39:8] read_data
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast
);

   swd_pkg::req_item_type req_item;
   swd_pkg::req_item_type held_item;
   swd_pkg::rsp_item_type step_result;
   swd_pkg::rsp_item_type rsp_item;
   logic                  held_valid;
   logic                  can_load;
   logic                  step;

   // The packed input matches the item layout; the top padding bits are dropped.
   assign req_item = swd_pkg::req_item_type'(req_tdata[$bits(swd_pkg::req_item_type)-1:0]);

   // The sequencer advances only when the result register has room.
   assign step = held_valid && can_load;

   swd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .take       (can_load),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   swd_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (held_item),
      .result (step_result)
   );

   swd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .load_item (step_result),
      .can_load  (can_load),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   assign rsp_tlast = rsp_item.done_res;
   assign rsp_tdata = {rsp_item.read_data, rsp_item.ack_bits, rsp_item.status,
                       rsp_item.swdio_drive, rsp_item.swdio_out};

endmodule

// ===== tb/testbench.sv =====
module testbench;

   // Tick positions within a well-formed transaction, counted from the start
   // tick: eight header ticks, one turnaround, three acknowledge ticks, then
   // the data phase.
   localparam int AckStart   = swd_pkg::HeaderBits + 1;
   localparam int DataStart  = AckStart + swd_pkg::AckBits;
   localparam int ParityTick = DataStart + swd_pkg::ReadBits;

   localparam int CycleLimit = 400000;

   // The block registers each item and then its result; spare cycles at the
   // end catch anything produced late or twice.
   localparam int DrainCycles = 8;

   // Length of the deliberate back-pressure stretch on the result side.
   localparam int HoldOffCycles = 300;

   // Expected contents of one result item. done travels as rsp_tlast.
   typedef struct packed {
      logic [swd_pkg::WordWidth-1:0] read_data;
      logic [swd_pkg::AckWidth-1:0]  ack_bits;
      logic [2:0]                    status;
      logic                          done;
      logic                          drive;
      logic                          level;
   } line_tick_type;

   // Tracks the sequencer tick by tick and keeps the line levels it expects,
   // oldest first.
   class swd_tick_scoreboard;
      swd_pkg::phase_type              ph = swd_pkg::PH_IDLE;
      logic [swd_pkg::CountWidth-1:0]  count = '0;
      logic [swd_pkg::WordWidth-1:0]   shifter = '0;
      logic [swd_pkg::HeaderWidth-1:0] hdr_q = '0;
      logic [swd_pkg::WordWidth-1:0]   wr_q = '0;
      logic [swd_pkg::AckWidth-1:0]    ack_q = '0;
      logic                            par_q = 1'b0;
      line_tick_type                   expected_ticks[$];
      int                              mismatches = 0;

      function bit is_idle();
         return ph == swd_pkg::PH_IDLE;
      endfunction

      function int pending();
         return expected_ticks.size();
      endfunction

      // Advance the predicted sequencer by one accepted tick.
      function void note_item(swd_pkg::req_item_type it);
         line_tick_type t;
         t = '0;
         case (ph)
            swd_pkg::PH_IDLE: begin
               t.drive = 1'b1;
               if (it.start_req) begin
                  hdr_q   = it.header;
                  wr_q    = it.write_data;
                  t.level = it.header[0];
                  count   = swd_pkg::CountWidth'(1);
                  ph      = swd_pkg::PH_HDR;
               end
            end
            swd_pkg::PH_HDR: begin
               t.drive = 1'b1;
               t.level = hdr_q[count[2:0]];
               count   = count + 1'b1;
               if (count >= swd_pkg::HeaderBits) begin
                  count = '0;
                  ph    = swd_pkg::PH_TURN;
               end
            end
            swd_pkg::PH_TURN: begin
               ack_q = '0;
               count = '0;
               ph    = swd_pkg::PH_ACK;
            end
            swd_pkg::PH_ACK: begin
               ack_q = ack_q | (swd_pkg::AckWidth'(it.line_in) << count[1:0]);
               count = count + 1'b1;
               if (count >= swd_pkg::AckBits) begin
                  count = '0;
                  if (ack_q == swd_pkg::ACK_OK) begin
                     if (hdr_q[swd_pkg::HeaderReadBit]) begin
                        shifter = '0;
                        par_q   = 1'b0;
                        ph      = swd_pkg::PH_READ;
                     end else begin
                        ph = swd_pkg::PH_WRITE;
                     end
                  end else if (ack_q == swd_pkg::ACK_WAIT ||
                               ack_q == swd_pkg::ACK_FAULT) begin
                     ph = swd_pkg::PH_LAST;
                  end else begin
                     ph = swd_pkg::PH_SKIP;
                  end
               end
            end
            swd_pkg::PH_READ: begin
               // The parity tick folds into the same accumulator as the data.
               par_q = par_q ^ it.line_in;
               if (count < swd_pkg::ReadBits) begin
                  shifter = {it.line_in, shifter[swd_pkg::WordWidth-1:1]};
                  count   = count + 1'b1;
               end else begin
                  count = '0;
                  ph    = swd_pkg::PH_LAST;
               end
            end
            swd_pkg::PH_WRITE: begin
               // Tick zero is the turnaround; the tail after parity is driven low.
               if (count >= 1) begin
                  t.drive = 1'b1;
                  if (count <= swd_pkg::ReadBits)
                     t.level = wr_q[5'(count - 1)];
                  else if (count == swd_pkg::WriteParity)
                     t.level = ^wr_q;
               end
               if (count >= swd_pkg::WriteLast) begin
                  t.done     = 1'b1;
                  t.status   = swd_pkg::ST_OK;
                  t.ack_bits = ack_q;
                  count      = '0;
                  ph         = swd_pkg::PH_IDLE;
               end else begin
                  count = count + 1'b1;
               end
            end
            swd_pkg::PH_LAST: begin
               t.done     = 1'b1;
               t.ack_bits = ack_q;
               if (ack_q == swd_pkg::ACK_OK) begin
                  t.status    = par_q ? swd_pkg::ST_PARITY : swd_pkg::ST_OK;
                  t.read_data = shifter;
               end else if (ack_q == swd_pkg::ACK_WAIT) begin
                  t.status = swd_pkg::ST_WAIT;
               end else begin
                  t.status = swd_pkg::ST_FAULT;
               end
               count = '0;
               ph    = swd_pkg::PH_IDLE;
            end
            default: begin
               if (count >= swd_pkg::SkipLast) begin
                  t.done     = 1'b1;
                  t.status   = swd_pkg::ST_NO_ACK;
                  t.ack_bits = ack_q;
                  count      = '0;
                  ph         = swd_pkg::PH_IDLE;
               end else begin
                  count = count + 1'b1;
               end
            end
         endcase
         expected_ticks.push_back(t);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(logic [swd_pkg::RspDataWidth-1:0] data, logic last);
         line_tick_type want;
         if (expected_ticks.size() == 0) begin
            $display("%0t: result %h (last %b) expected nothing, got an item",
                     $time, data, last);
            mismatches++;
            return;
         end
         want = expected_ticks.pop_front();
         compare_field("swdio_out", want.level, data[0]);
         compare_field("swdio_drive", want.drive, data[1]);
         compare_field("status", want.status, data[4:2]);
         compare_field("ack_bits", want.ack_bits, data[7:5]);
         compare_field("read_data", want.read_data, data[39:8]);
         compare_field("done (tlast)", want.done, last);
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [swd_pkg::ReqDataWidth-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [swd_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                             rsp_tlast;

   // Percentages of cycles in which each side idles; changed between phases.
   int sender_idle_pct;
   int receiver_idle_pct;
   int items_sent;
   int random_base;
   int cycle_count;
   bit hold_request;

   swd_tick_scoreboard sb = new;

   swd_host_transaction_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // An item with random content throughout; only start_req is chosen.
   function automatic swd_pkg::req_item_type random_item(bit start);
      swd_pkg::req_item_type it;
      it.start_req  = start;
      it.header     = swd_pkg::HeaderWidth'($urandom_range(255));
      it.write_data = $urandom;
      it.line_in    = 1'($urandom_range(1));
      return it;
   endfunction

   // Offer one item, after a random gap, and hold it until the block takes it.
   // The predictor is advanced at the very edge that accepts the item.
   task automatic send_item(swd_pkg::req_item_type it);
      int gap;
      gap = 0;
      while (gap < 12 && $urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= swd_pkg::ReqDataWidth'(it);
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.note_item(it);
      items_sent++;
   endtask

   // Play out a complete transaction from an idle block. The target side is
   // modelled by the line_in bits: the acknowledge, and for an OK read the
   // data word followed by its parity bit, deliberately wrong on request.
   // Every other field of the ticks after the start is random, so starts
   // offered while busy are exercised as a matter of course.
   task automatic send_transaction(logic [swd_pkg::HeaderWidth-1:0] hdr,
                                   logic [swd_pkg::WordWidth-1:0] wdat,
                                   logic [swd_pkg::AckWidth-1:0] ack,
                                   logic [swd_pkg::WordWidth-1:0] word,
                                   bit bad_parity);
      swd_pkg::req_item_type it;
      bit                    is_read;
      int                    tail;
      is_read = (ack == swd_pkg::ACK_OK) && hdr[swd_pkg::HeaderReadBit];
      if (ack == swd_pkg::ACK_OK)
         tail = is_read ? swd_pkg::ReadBits + 2 : swd_pkg::WriteLast + 1;
      else if (ack == swd_pkg::ACK_WAIT || ack == swd_pkg::ACK_FAULT)
         tail = 1;
      else
         tail = swd_pkg::SkipLast + 1;
      for (int k = 0; k < DataStart + tail; k++) begin
         it = random_item(1'($urandom_range(1)));
         if (k == 0) begin
            it.start_req  = 1'b1;
            it.header     = hdr;
            it.write_data = wdat;
         end else if (k >= AckStart && k < DataStart) begin
            it.line_in = ack[k - AckStart];
         end else if (is_read && k >= DataStart && k < ParityTick) begin
            it.line_in = word[k - DataStart];
         end else if (is_read && k == ParityTick) begin
            it.line_in = (^word) ^ bad_parity;
         end
         send_item(it);
      end
   endtask

   // Stop offering items until every expected result has come back.
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // Mostly well-formed transactions with random content and acknowledge,
   // separated by a few quiet ticks; now and then a burst of noise, after
   // which quiet ticks carry the block back to idle.
   task automatic run_random(int upto);
      int                           pick;
      int                           burst;
      logic [swd_pkg::AckWidth-1:0] ack;
      while (items_sent < upto) begin
         if (!hold_request && items_sent > random_base + 200)
            hold_request = 1'b1;
         pick = $urandom_range(99);
         if (pick < 8) begin
            burst = $urandom_range(30, 5);
            repeat (burst) send_item(random_item($urandom_range(3) == 0));
            while (!sb.is_idle())
               send_item(random_item(1'b0));
         end else begin
            pick = $urandom_range(99);
            if (pick < 55)
               ack = swd_pkg::ACK_OK;
            else if (pick < 70)
               ack = swd_pkg::ACK_WAIT;
            else if (pick < 82)
               ack = swd_pkg::ACK_FAULT;
            else begin
               do
                  ack = swd_pkg::AckWidth'($urandom_range(7));
               while (ack == swd_pkg::ACK_OK || ack == swd_pkg::ACK_WAIT ||
                      ack == swd_pkg::ACK_FAULT);
            end
            repeat ($urandom_range(2)) send_item(random_item(1'b0));
            send_transaction(swd_pkg::HeaderWidth'($urandom_range(255)), $urandom, ack,
                             $urandom, $urandom_range(3) == 0);
         end
      end
   endtask

   // Result side: random back-pressure, plus one long hold-off on request,
   // counted here so that the sender keeps offering items and the block
   // fills up and stalls its input.
   initial begin
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HoldOffCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tlast);
      end
   end

   // Watchdog: a stuck handshake or a lost result ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // Stimulus and the verdict.
   initial begin
      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      items_sent        = 0;
      hold_request      = 1'b0;
      sender_idle_pct   = 18;
      receiver_idle_pct = 68;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Quiet ticks first, then reads and writes with the
      // header and data words at their extremes, a read whose parity bit is
      // wrong, WAIT and FAULT, and every acknowledge pattern that is not a
      // valid code.
      repeat (2) send_item(random_item(1'b0));
      send_transaction('1, '1, swd_pkg::ACK_OK, '1, 1'b0);
      send_transaction(swd_pkg::HeaderWidth'(1 << swd_pkg::HeaderReadBit), '0,
                       swd_pkg::ACK_OK, '0, 1'b1);
      send_transaction('0, '1, swd_pkg::ACK_OK, $urandom, 1'b0);
      send_transaction(~swd_pkg::HeaderWidth'(1 << swd_pkg::HeaderReadBit), '0,
                       swd_pkg::ACK_OK, $urandom, 1'b0);
      send_transaction(swd_pkg::HeaderWidth'($urandom_range(255)), $urandom,
                       swd_pkg::ACK_WAIT, $urandom, 1'b0);
      send_transaction(swd_pkg::HeaderWidth'($urandom_range(255)), $urandom,
                       swd_pkg::ACK_FAULT, $urandom, 1'b0);
      for (int a = 0; a < (1 << swd_pkg::AckWidth); a++) begin
         if (a != swd_pkg::ACK_OK && a != swd_pkg::ACK_WAIT && a != swd_pkg::ACK_FAULT)
            send_transaction(swd_pkg::HeaderWidth'($urandom_range(255)), $urandom,
                             swd_pkg::AckWidth'(a), $urandom, 1'b0);
      end

      // Random part in three phases: a mostly busy sender against a slow
      // receiver, then the reverse, then both at full rate. The sender waits
      // for the block to drain between phases.
      random_base = items_sent;
      run_random(random_base + 460);
      pause_until_drained();
      sender_idle_pct   = 68;
      receiver_idle_pct = 18;
      run_random(random_base + 920);
      pause_until_drained();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      run_random(random_base + 1390);

      pause_until_drained();
      repeat (DrainCycles) @(posedge clock);
      if (sb.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
